FILE: src/gdr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdr_pkg
// Shared constants, codes and payload types of the grid DDA ray caster.
// ----------------------------------------------------------------------------
package gdr_pkg;

    localparam int MAP_SIZE     = 64;
    localparam int MAP_AW       = $clog2(MAP_SIZE);
    localparam int CELL_AW      = 2 * MAP_AW;
    localparam int CELL_DEPTH   = MAP_SIZE * MAP_SIZE;
    localparam int SCREEN_WIDTH = 1024;
    localparam int FRAC_BITS    = 16;
    localparam int ONE          = 1 << FRAC_BITS;

    localparam int CAM_SHIFT    = FRAC_BITS + 1 - $clog2(SCREEN_WIDTH);
    localparam int CAM_W        = FRAC_BITS + 2;
    localparam int DIR_W        = 19;
    localparam int POS_W        = 22;
    localparam int RAY_W        = FRAC_BITS + 5;
    localparam int MAG_W        = FRAC_BITS + 3;
    localparam int DELTA_W      = FRAC_BITS + 10;
    localparam int SD_W         = FRAC_BITS + 19;
    localparam int MUL_A_W      = DELTA_W + 1;
    localparam int MUL_B_W      = DIR_W;
    localparam int PROD_W       = MUL_A_W + MUL_B_W;
    localparam int POSI_W       = MAP_AW + 2;
    localparam int DIV_SAT_MAG  = 1 << (FRAC_BITS - 10);
    localparam int DIST_W       = 24;
    localparam int DIST_MAX     = (1 << DIST_W) - 1;

    localparam int CFG_IDX_W    = 3;
    localparam int CFG_W        = 22;

    localparam logic [CFG_IDX_W-1:0] CFG_PLAYER_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PLAYER_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DIR_X    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DIR_Y    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PLANE_X  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PLANE_Y  = 3'd5;

    localparam logic [DIR_W-1:0] DIR_X_RST   = 19'd65536;
    localparam logic [DIR_W-1:0] DIR_Y_RST   = 19'd0;
    localparam logic [DIR_W-1:0] PLANE_X_RST = 19'd0;
    localparam logic [DIR_W-1:0] PLANE_Y_RST = 19'd43253;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_CAST  = 1'b1;

    localparam logic [1:0] KIND_EMPTY  = 2'd0;
    localparam logic [1:0] KIND_WALL   = 2'd1;
    localparam logic [1:0] KIND_CLOSED = 2'd2;
    localparam logic [1:0] KIND_OPEN   = 2'd3;

    typedef struct packed {
        logic       cmd;
        logic [5:0] cell_row;
        logic [5:0] cell_col;
        logic [1:0] cell_kind;
        logic [9:0] screen_column;
    } in_item_t;

    typedef struct packed {
        logic [23:0] wall_distance;
        logic        hit_side;
        logic [5:0]  hit_col;
        logic [5:0]  hit_row;
        logic        hit_is_door;
        logic        passed_open_door;
    } out_item_t;

    typedef struct packed {
        logic     valid;
        logic     cast;
        logic     wr_ok;
        in_item_t item;
    } q_head_t;

endpackage

FILE: src/gdr_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module gdr_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: src/gdr_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdr_front
// Input side: accepts items, classifies them and queues them for the engine.
// ----------------------------------------------------------------------------
module gdr_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  gdr_pkg::in_item_t in_data,
    input  logic              clearing,
    output gdr_pkg::q_head_t  head,
    input  logic              take
);
    import gdr_pkg::*;

    localparam int QD = 2;

    typedef struct packed {
        logic     cast;
        logic     wr_ok;
        in_item_t item;
    } q_entry_t;

    q_entry_t   entry_reg [QD];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       accept;
    logic       pop;
    q_entry_t   new_entry;

    assign in_stall = (count_reg == 2'(QD)) || clearing;
    assign accept   = in_valid && !in_stall;
    assign pop      = take && (count_reg != 2'd0);

    always_comb
    begin
        new_entry.cast  = (in_data.cmd == CMD_CAST);
        new_entry.wr_ok = ({1'b0, in_data.cell_row} < 7'(MAP_SIZE))
                       && ({1'b0, in_data.cell_col} < 7'(MAP_SIZE));
        new_entry.item  = in_data;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            entry_reg[wr_ptr_reg] <= new_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (accept)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_reg + 2'(accept) - 2'(pop);
        end
    end

    always_comb
    begin
        head.valid = (count_reg != 2'd0);
        head.cast  = entry_reg[rd_ptr_reg].cast;
        head.wr_ok = entry_reg[rd_ptr_reg].wr_ok;
        head.item  = entry_reg[rd_ptr_reg].item;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 2'(QD))
        else $error("queue count over depth");

    a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |=> $stable(count_reg) || $fell(count_reg != 2'd0) || count_reg == 2'd0)
        else $error("queue grew during clearing pass");

endmodule

FILE: src/gdr_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdr_back
// Cast engine: map store, ray setup, reciprocal divide, DDA walk, result.
// ----------------------------------------------------------------------------
module gdr_back (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [gdr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [gdr_pkg::CFG_W-1:0]       cfg_wdata,
    input  gdr_pkg::q_head_t                head,
    output logic                            take,
    output logic                            clearing,
    output logic                            out_valid,
    input  logic                            out_stall,
    output gdr_pkg::out_item_t              out_data
);
    import gdr_pkg::*;

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_MULX, ST_MULY, ST_RAYY, ST_DIVX, ST_DIVY,
        ST_SDX, ST_SDY, ST_SDFIN, ST_STEP, ST_TEST, ST_DONE
    } state_t;

    state_t state_reg, state_next;

    logic [POS_W-1:0]        px_reg, py_reg;
    logic signed [DIR_W-1:0] dir_x_reg, dir_y_reg, plane_x_reg, plane_y_reg;

    logic [CELL_AW-1:0]      clr_reg, clr_next;
    logic signed [CAM_W-1:0] cam_reg, cam_next;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [RAY_W-1:0] rdx_reg, rdx_next, rdy_reg, rdy_next;
    logic [MAG_W-1:0]        mag_reg, mag_next;
    logic [MAG_W-1:0]        rem_reg, rem_next;
    logic [DELTA_W-1:0]      q_reg, q_next;
    logic [4:0]              cnt_reg, cnt_next;
    logic                    sat_reg, sat_next;
    logic [DELTA_W-1:0]      dx_reg, dx_next, dy_reg, dy_next;
    logic [SD_W-1:0]         sdx_reg, sdx_next, sdy_reg, sdy_next;
    logic [POSI_W-1:0]       mx_reg, mx_next, my_reg, my_next;
    logic                    side_reg, side_next;
    logic                    door_reg, door_next;
    logic                    open_reg, open_next;
    logic                    out_valid_reg, out_valid_next;
    out_item_t               out_reg, out_next;

    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  prod_sh;
    logic [MAG_W:0]            rem2;
    logic [DELTA_W-1:0]        q_step;
    logic [MAG_W-1:0]          rem_step;
    logic [RAY_W-1:0]          rdx_abs, rdy_abs;
    logic [FRAC_BITS:0]        fx, fy;
    logic                      take_x;
    logic [POSI_W-1:0]         nmx, nmy;
    logic                      oob;
    logic [SD_W-1:0]           dist_raw;
    logic [MAP_AW-1:0]         cx, cy;

    logic                 ram_we;
    logic [CELL_AW-1:0]   ram_waddr, ram_raddr;
    logic [1:0]           ram_wdata, ram_rdata;

    gdr_ram #(
        .WIDTH (2),
        .DEPTH (CELL_DEPTH)
    ) u_cells (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign prod_sh = prod_reg >>> FRAC_BITS;
    assign rem2    = {rem_reg, 1'b0};
    assign rdx_abs = rdx_reg[RAY_W-1] ? (~rdx_reg + 1'b1) : rdx_reg;
    assign rdy_abs = rdy_reg[RAY_W-1] ? (~rdy_reg + 1'b1) : rdy_reg;
    assign fx = rdx_reg[RAY_W-1] ? {1'b0, px_reg[FRAC_BITS-1:0]}
                                 : (FRAC_BITS+1)'(ONE) - {1'b0, px_reg[FRAC_BITS-1:0]};
    assign fy = rdy_reg[RAY_W-1] ? {1'b0, py_reg[FRAC_BITS-1:0]}
                                 : (FRAC_BITS+1)'(ONE) - {1'b0, py_reg[FRAC_BITS-1:0]};
    assign take_x = sdx_reg < sdy_reg;
    assign nmx = take_x ? (rdx_reg[RAY_W-1] ? mx_reg - 1'b1 : mx_reg + 1'b1) : mx_reg;
    assign nmy = take_x ? my_reg : (rdy_reg[RAY_W-1] ? my_reg - 1'b1 : my_reg + 1'b1);
    assign oob = nmx[POSI_W-1] || (nmx[POSI_W-2:0] >= (POSI_W-1)'(MAP_SIZE))
              || nmy[POSI_W-1] || (nmy[POSI_W-2:0] >= (POSI_W-1)'(MAP_SIZE));
    assign dist_raw = side_reg ? (sdy_reg - SD_W'(dy_reg)) : (sdx_reg - SD_W'(dx_reg));
    assign cx = mx_reg[POSI_W-1] ? '0 :
                (mx_reg[POSI_W-2:0] >= (POSI_W-1)'(MAP_SIZE)) ? MAP_AW'(MAP_SIZE - 1)
                                                               : mx_reg[MAP_AW-1:0];
    assign cy = my_reg[POSI_W-1] ? '0 :
                (my_reg[POSI_W-2:0] >= (POSI_W-1)'(MAP_SIZE)) ? MAP_AW'(MAP_SIZE - 1)
                                                               : my_reg[MAP_AW-1:0];

    always_comb
    begin
        if (rem2 >= {1'b0, mag_reg})
        begin
            rem_step = MAG_W'(rem2 - {1'b0, mag_reg});
            q_step   = {q_reg[DELTA_W-2:0], 1'b1};
        end
        else
        begin
            rem_step = rem2[MAG_W-1:0];
            q_step   = {q_reg[DELTA_W-2:0], 1'b0};
        end
    end

    always_comb
    begin
        mul_a = {{(MUL_A_W-CAM_W){cam_reg[CAM_W-1]}}, cam_reg};
        mul_b = plane_x_reg;
        case (state_reg)
            ST_MULY:
            begin
                mul_b = plane_y_reg;
            end
            ST_SDX:
            begin
                mul_a = $signed({1'b0, dx_reg});
                mul_b = $signed({{(MUL_B_W-FRAC_BITS-1){1'b0}}, fx});
            end
            ST_SDY:
            begin
                mul_a = $signed({1'b0, dy_reg});
                mul_b = $signed({{(MUL_B_W-FRAC_BITS-1){1'b0}}, fy});
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        cam_next       = cam_reg;
        rdx_next       = rdx_reg;
        rdy_next       = rdy_reg;
        mag_next       = mag_reg;
        rem_next       = rem_reg;
        q_next         = q_reg;
        cnt_next       = cnt_reg;
        sat_next       = sat_reg;
        dx_next        = dx_reg;
        dy_next        = dy_reg;
        sdx_next       = sdx_reg;
        sdy_next       = sdy_reg;
        mx_next        = mx_reg;
        my_next        = my_reg;
        side_next      = side_reg;
        door_next      = door_reg;
        open_next      = open_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && out_stall;
        take           = 1'b0;
        ram_we         = 1'b0;
        ram_waddr      = clr_reg;
        ram_wdata      = KIND_EMPTY;
        ram_raddr      = {nmy[MAP_AW-1:0], nmx[MAP_AW-1:0]};

        case (state_reg)
            ST_CLEAR:
            begin
                ram_we   = 1'b1;
                clr_next = clr_reg + 1'b1;
                if (&clr_reg)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (head.valid)
                begin
                    take = 1'b1;
                    if (head.cast)
                    begin
                        cam_next = $signed({1'b0, head.item.screen_column,
                                            {CAM_SHIFT{1'b0}}}) - $signed(CAM_W'(ONE));
                        state_next = ST_MULX;
                    end
                    else
                    begin
                        ram_we    = head.wr_ok;
                        ram_waddr = {head.item.cell_row, head.item.cell_col};
                        ram_wdata = head.item.cell_kind;
                    end
                end
            end
            ST_MULX:
            begin
                state_next = ST_MULY;
            end
            ST_MULY:
            begin
                rdx_next = $signed({{(RAY_W-DIR_W){dir_x_reg[DIR_W-1]}}, dir_x_reg})
                         + $signed(prod_sh[RAY_W-1:0]);
                state_next = ST_RAYY;
            end
            ST_RAYY:
            begin
                rdy_next = $signed({{(RAY_W-DIR_W){dir_y_reg[DIR_W-1]}}, dir_y_reg})
                         + $signed(prod_sh[RAY_W-1:0]);
                mag_next = rdx_abs[MAG_W-1:0];
                sat_next = (rdx_abs <= RAY_W'(DIV_SAT_MAG));
                rem_next = MAG_W'(DIV_SAT_MAG);
                q_next   = '0;
                cnt_next = '0;
                state_next = ST_DIVX;
            end
            ST_DIVX, ST_DIVY:
            begin
                rem_next = rem_step;
                q_next   = q_step;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == 5'(DELTA_W - 1))
                begin
                    if (state_reg == ST_DIVX)
                    begin
                        dx_next  = sat_reg ? '1 : q_step;
                        mag_next = rdy_abs[MAG_W-1:0];
                        sat_next = (rdy_abs <= RAY_W'(DIV_SAT_MAG));
                        rem_next = MAG_W'(DIV_SAT_MAG);
                        q_next   = '0;
                        cnt_next = '0;
                        state_next = ST_DIVY;
                    end
                    else
                    begin
                        dy_next    = sat_reg ? '1 : q_step;
                        state_next = ST_SDX;
                    end
                end
            end
            ST_SDX:
            begin
                state_next = ST_SDY;
            end
            ST_SDY:
            begin
                sdx_next   = prod_sh[SD_W-1:0];
                state_next = ST_SDFIN;
            end
            ST_SDFIN:
            begin
                sdy_next   = prod_sh[SD_W-1:0];
                mx_next    = {2'b00, px_reg[POS_W-1:FRAC_BITS]};
                my_next    = {2'b00, py_reg[POS_W-1:FRAC_BITS]};
                door_next  = 1'b0;
                open_next  = 1'b0;
                side_next  = 1'b0;
                state_next = ST_STEP;
            end
            ST_STEP:
            begin
                mx_next = nmx;
                my_next = nmy;
                if (take_x)
                begin
                    sdx_next  = sdx_reg + SD_W'(dx_reg);
                    side_next = 1'b0;
                end
                else
                begin
                    sdy_next  = sdy_reg + SD_W'(dy_reg);
                    side_next = 1'b1;
                end
                if (oob)
                begin
                    door_next  = 1'b0;
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_TEST;
                end
            end
            ST_TEST:
            begin
                case (ram_rdata)
                    KIND_WALL:
                    begin
                        door_next  = 1'b0;
                        state_next = ST_DONE;
                    end
                    KIND_CLOSED:
                    begin
                        door_next  = 1'b1;
                        open_next  = 1'b0;
                        state_next = ST_DONE;
                    end
                    KIND_OPEN:
                    begin
                        door_next  = 1'b0;
                        open_next  = 1'b1;
                        state_next = ST_STEP;
                    end
                    default:
                    begin
                        state_next = ST_STEP;
                    end
                endcase
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next            = 1'b1;
                    out_next.wall_distance    = (dist_raw > SD_W'(DIST_MAX))
                                              ? DIST_W'(DIST_MAX) : dist_raw[DIST_W-1:0];
                    out_next.hit_side         = side_reg;
                    out_next.hit_col          = cx;
                    out_next.hit_row          = cy;
                    out_next.hit_is_door      = door_reg;
                    out_next.passed_open_door = open_reg;
                    state_next                = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        cam_reg  <= cam_next;
        rdx_reg  <= rdx_next;
        rdy_reg  <= rdy_next;
        mag_reg  <= mag_next;
        rem_reg  <= rem_next;
        q_reg    <= q_next;
        cnt_reg  <= cnt_next;
        sat_reg  <= sat_next;
        dx_reg   <= dx_next;
        dy_reg   <= dy_next;
        sdx_reg  <= sdx_next;
        sdy_reg  <= sdy_next;
        mx_reg   <= mx_next;
        my_reg   <= my_next;
        side_reg <= side_next;
        door_reg <= door_next;
        open_reg <= open_next;
        out_reg  <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
            px_reg        <= '0;
            py_reg        <= '0;
            dir_x_reg     <= DIR_X_RST;
            dir_y_reg     <= DIR_Y_RST;
            plane_x_reg   <= PLANE_X_RST;
            plane_y_reg   <= PLANE_Y_RST;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    CFG_PLAYER_X: px_reg      <= cfg_wdata;
                    CFG_PLAYER_Y: py_reg      <= cfg_wdata;
                    CFG_DIR_X:    dir_x_reg   <= cfg_wdata[DIR_W-1:0];
                    CFG_DIR_Y:    dir_y_reg   <= cfg_wdata[DIR_W-1:0];
                    CFG_PLANE_X:  plane_x_reg <= cfg_wdata[DIR_W-1:0];
                    CFG_PLANE_Y:  plane_y_reg <= cfg_wdata[DIR_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    assign clearing  = (state_reg == ST_CLEAR);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
        take |-> (state_reg == ST_IDLE))
        else $error("queue pop outside idle");

    a_no_write_walk: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_STEP || state_reg == ST_TEST) |-> !ram_we)
        else $error("map write during walk");

    a_test_after_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_TEST) |-> $past(state_reg == ST_STEP))
        else $error("cell test without step");

endmodule

FILE: src/grid_dda_raycaster.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_dda_raycaster
// Grid map of 2-bit cells with one DDA ray cast per screen column.
// ----------------------------------------------------------------------------
// After reset the block sweeps the 64x64 map store to empty, one cell per
// cycle; no item is taken then (configuration writes are).
// A cell write is done in the engine's idle state as it is taken. A cast
// runs its setup (two camera multiplies, two reciprocal divides on one
// shared divider, two side-distance multiplies) and then walks the map
// cell by cell, with a registered map read for each cell visited.
// A two-entry queue lets the next items transfer while a cast runs, and an
// output register holds a finished result until it is taken.
module grid_dda_raycaster (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  gdr_pkg::in_item_t             in_data,
    output logic                          out_valid,
    input  logic                          out_stall,
    output gdr_pkg::out_item_t            out_data,
    input  logic                          cfg_wr_en,
    input  logic [gdr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [gdr_pkg::CFG_W-1:0]     cfg_wdata
);
    import gdr_pkg::*;

    q_head_t head;
    logic    take;
    logic    clearing;

    gdr_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .clearing (clearing),
        .head     (head),
        .take     (take)
    );

    gdr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .head      (head),
        .take      (take),
        .clearing  (clearing),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

FILE: tb/grid_dda_raycaster_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_dda_raycaster_tb
// Self-checking bench for the grid DDA ray caster.
// Map writes and column casts are sent through the input channel.
// A local copy of the map and the view registers traces each cast cell by cell.
// Every returned hit is compared field by field with the oldest traced hit.
// Both channels idle at random, and the view is reloaded between phases.
// ----------------------------------------------------------------------------
module grid_dda_raycaster_tb;

    import gdr_pkg::*;

    localparam int     HALF_PERIOD = 4;
    localparam int     WATCHDOG    = 20000;
    localparam int     SETTLE      = 400;
    localparam longint DELTA_SAT   = (longint'(1) << 26) - 1;
    localparam longint FRAC_MASK   = 65535;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    in_item_t in_data = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    out_item_t out_data;
    logic cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0] cfg_wdata = '0;

    logic [1:0] shadow_map [CELL_DEPTH];
    longint pos_x, pos_y, dir_x, dir_y, plane_x, plane_y;
    out_item_t pending_hits [$];

    int errors = 0;
    int n_writes = 0;
    int n_casts = 0;
    int n_hits = 0;
    int n_doors = 0;
    int n_open = 0;
    int burst_left = 0;
    bit no_gaps = 1'b0;
    bit valid_held = 1'b0;
    int idle_cycles = 0;
    int stall_run = 0;
    int stall_mode = 0;

    grid_dda_raycaster i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #(HALF_PERIOD) clk = ~clk;

    function automatic longint ray_delta(input longint comp);
        longint mag;
        longint d;
        mag = (comp < 0) ? -comp : comp;
        if (mag == 0)
            return DELTA_SAT;
        d = (longint'(1) << 32) / mag;
        return (d > DELTA_SAT) ? DELTA_SAT : d;
    endfunction

    function automatic longint clamp_cell(input longint c);
        if (c < 0)
            return 0;
        if (c >= MAP_SIZE)
            return MAP_SIZE - 1;
        return c;
    endfunction

    function automatic out_item_t trace_ray(input logic [9:0] column);
        longint cam, rdx, rdy, mx, my, sx, sy, dx, dy, sdx, sdy, hit_dist;
        logic [1:0] kind;
        bit side;
        bit door;
        bit open_seen;
        bit hit;
        out_item_t r;
        cam = ((2 * longint'(column)) << 16) / SCREEN_WIDTH - ONE;
        rdx = dir_x + ((plane_x * cam) >>> 16);
        rdy = dir_y + ((plane_y * cam) >>> 16);
        mx = pos_x >> 16;
        my = pos_y >> 16;
        dx = ray_delta(rdx);
        dy = ray_delta(rdy);
        sx = (rdx < 0) ? -1 : 1;
        sy = (rdy < 0) ? -1 : 1;
        sdx = (rdx < 0) ? (((pos_x & FRAC_MASK) * dx) >> 16)
                        : (((ONE - (pos_x & FRAC_MASK)) * dx) >> 16);
        sdy = (rdy < 0) ? (((pos_y & FRAC_MASK) * dy) >> 16)
                        : (((ONE - (pos_y & FRAC_MASK)) * dy) >> 16);
        side = 1'b0;
        door = 1'b0;
        open_seen = 1'b0;
        hit = 1'b0;
        for (int n = 0; n < 2 * MAP_SIZE + 4 && !hit; n++)
        begin
            if (sdx < sdy)
            begin
                sdx += dx;
                mx += sx;
                side = 1'b0;
            end
            else
            begin
                sdy += dy;
                my += sy;
                side = 1'b1;
            end
            if (mx < 0 || my < 0 || mx >= MAP_SIZE || my >= MAP_SIZE)
            begin
                door = 1'b0;
                hit = 1'b1;
            end
            else
            begin
                kind = shadow_map[my * MAP_SIZE + mx];
                if (kind == KIND_WALL)
                begin
                    door = 1'b0;
                    hit = 1'b1;
                end
                else if (kind == KIND_CLOSED)
                begin
                    door = 1'b1;
                    open_seen = 1'b0;
                    hit = 1'b1;
                end
                else if (kind == KIND_OPEN)
                begin
                    door = 1'b0;
                    open_seen = 1'b1;
                end
            end
        end
        hit_dist = side ? (sdy - dy) : (sdx - dx);
        if (hit_dist > DIST_MAX)
            hit_dist = DIST_MAX;
        r.wall_distance    = hit_dist[23:0];
        r.hit_side         = side;
        r.hit_col          = 6'(clamp_cell(mx));
        r.hit_row          = 6'(clamp_cell(my));
        r.hit_is_door      = door;
        r.passed_open_door = open_seen;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("%0t mismatch %s: got %0d want %0d", $time, what, got, want);
        errors++;
    endtask

    // check each result transfer against the oldest traced hit
    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_hits.size() == 0)
                report_mismatch("unexpected result", out_data.wall_distance, 0);
            else
            begin
                want = pending_hits.pop_front();
                n_hits++;
                if (out_data.wall_distance != want.wall_distance)
                    report_mismatch("wall_distance", out_data.wall_distance,
                                    want.wall_distance);
                if (out_data.hit_side != want.hit_side)
                    report_mismatch("hit_side", out_data.hit_side, want.hit_side);
                if (out_data.hit_col != want.hit_col)
                    report_mismatch("hit_col", out_data.hit_col, want.hit_col);
                if (out_data.hit_row != want.hit_row)
                    report_mismatch("hit_row", out_data.hit_row, want.hit_row);
                if (out_data.hit_is_door != want.hit_is_door)
                    report_mismatch("hit_is_door", out_data.hit_is_door, want.hit_is_door);
                if (out_data.passed_open_door != want.passed_open_door)
                    report_mismatch("passed_open_door", out_data.passed_open_door,
                                    want.passed_open_door);
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            stall_run  <= 0;
            stall_mode <= 0;
        end
        else
        begin
            if (stall_run == 0)
            begin
                stall_mode <= $urandom_range(0, 3);
                stall_run  <= $urandom_range(20, 200);
            end
            else
                stall_run <= stall_run - 1;
            case (stall_mode)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(0, 3) == 0);
                2: out_stall <= 1'($urandom_range(0, 1));
                default: out_stall <= ($urandom_range(0, 9) < 8);
            endcase
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG)
        begin
            $display("%0t watchdog expired, %0d hits outstanding", $time, pending_hits.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic send_item(input in_item_t it);
        in_data  <= it;
        in_valid <= 1'b1;
        valid_held = 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (it.cmd == CMD_WRITE)
        begin
            shadow_map[it.cell_row * MAP_SIZE + it.cell_col] = it.cell_kind;
            n_writes++;
        end
        else
        begin
            pending_hits.push_back(trace_ray(it.screen_column));
            if (pending_hits[$].hit_is_door)
                n_doors++;
            if (pending_hits[$].passed_open_door)
                n_open++;
            n_casts++;
        end
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(0, 12);
            if (!no_gaps && $urandom_range(0, 3) != 0)
            begin
                in_valid <= 1'b0;
                valid_held = 1'b0;
                repeat ($urandom_range(1, 9))
                    @(posedge clk);
            end
        end
    endtask

    task automatic write_cell(input int row, input int col, input logic [1:0] kind);
        in_item_t it;
        it = in_item_t'($urandom);
        it.cmd       = CMD_WRITE;
        it.cell_row  = 6'(row);
        it.cell_col  = 6'(col);
        it.cell_kind = kind;
        send_item(it);
    endtask

    task automatic cast_column(input int column);
        in_item_t it;
        it = in_item_t'($urandom);
        it.cmd           = CMD_CAST;
        it.screen_column = 10'(column);
        send_item(it);
    endtask

    // drop valid, wait for every hit, then let trailing writes finish
    task automatic settle_engine();
        if (valid_held)
            in_valid <= 1'b0;
        valid_held = 1'b0;
        while (pending_hits.size() != 0)
            @(posedge clk);
        repeat (SETTLE)
            @(posedge clk);
    endtask

    task automatic load_view(input longint px, input longint py, input longint dxv,
                             input longint dyv, input longint plx, input longint ply);
        logic [CFG_IDX_W-1:0] idx [6];
        longint val [6];
        idx = '{CFG_PLAYER_X, CFG_PLAYER_Y, CFG_DIR_X, CFG_DIR_Y, CFG_PLANE_X, CFG_PLANE_Y};
        val = '{px, py, dxv, dyv, plx, ply};
        for (int i = 0; i < 6; i++)
        begin
            cfg_wr_en <= 1'b1;
            cfg_index <= idx[i];
            cfg_wdata <= CFG_W'(val[i]);
            @(posedge clk);
        end
        cfg_wr_en <= 1'b0;
        pos_x   = px;
        pos_y   = py;
        dir_x   = dxv;
        dir_y   = dyv;
        plane_x = plx;
        plane_y = ply;
    endtask

    task automatic test_reset_view();
        cast_column(0);
        cast_column(512);
        cast_column(1023);
        settle_engine();
    endtask

    task automatic test_door_walk();
        load_view(688128, 688128, 65536, 0, 0, 43253);
        write_cell(10, 12, KIND_OPEN);
        write_cell(10, 14, KIND_WALL);
        cast_column(512);
        write_cell(10, 13, KIND_CLOSED);
        cast_column(512);
        write_cell(10, 12, KIND_EMPTY);
        write_cell(10, 13, KIND_WALL);
        cast_column(512);
        cast_column(0);
        cast_column(1023);
        settle_engine();
    endtask

    task automatic test_axis_cases();
        load_view(688128, 688128, 0, 65536, 0, 0);
        cast_column(512);
        cast_column(0);
        settle_engine();
        load_view(32768, 32768, 65536, 65536, 0, 0);
        cast_column(512);
        settle_engine();
    endtask

    task automatic test_extremes();
        load_view(4194303, 4194303, -131072, -131072, 131072, -131072);
        write_cell(63, 63, KIND_WALL);
        write_cell(0, 0, KIND_CLOSED);
        cast_column(0);
        cast_column(1023);
        cast_column(512);
        settle_engine();
        load_view(0, 0, 131072, 131072, -131072, 131072);
        cast_column(0);
        cast_column(1023);
        settle_engine();
    endtask

    function automatic longint rand_comp();
        if ($urandom_range(0, 5) == 0)
            return 0;
        return longint'($urandom_range(0, 262144)) - 131072;
    endfunction

    function automatic logic [1:0] rand_kind();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return KIND_EMPTY;
        if (r < 65)
            return KIND_WALL;
        if (r < 80)
            return KIND_CLOSED;
        return KIND_OPEN;
    endfunction

    task automatic test_random_scenes();
        int pr, pc, r;
        for (int phase = 0; phase < 6; phase++)
        begin
            no_gaps = phase[0];
            if (phase == 5)
                load_view(4194303, 0, -131072, 131072, 131072, 131072);
            else
                load_view($urandom_range(0, 4194303), $urandom_range(0, 4194303),
                          rand_comp(), rand_comp(), rand_comp(), rand_comp());
            pr = int'(pos_y >> 16);
            pc = int'(pos_x >> 16);
            for (int k = 0; k < 160; k++)
            begin
                r = $urandom_range(0, 99);
                if (r < 35)
                    write_cell((pr + $urandom_range(0, 16) + 56) % MAP_SIZE,
                               (pc + $urandom_range(0, 16) + 56) % MAP_SIZE, rand_kind());
                else if (r < 40)
                    write_cell($urandom_range(0, 63), $urandom_range(0, 63), rand_kind());
                else
                    cast_column($urandom_range(0, 1023));
            end
            settle_engine();
        end
    endtask

    initial
    begin
        foreach (shadow_map[i])
            shadow_map[i] = KIND_EMPTY;
        pos_x   = 0;
        pos_y   = 0;
        dir_x   = 65536;
        dir_y   = 0;
        plane_x = 0;
        plane_y = 43253;
        repeat (6)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_view();
        test_door_walk();
        test_axis_cases();
        test_extremes();
        test_random_scenes();
        $display("Covered %0d cell writes and %0d casts, %0d hits checked.",
                 n_writes, n_casts, n_hits);
        $display("Closed-door hits: %0d, rays through open doors: %0d.", n_doors, n_open);
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
